// ----- src/wmbls_pkg.sv -----
package wmbls_pkg;

  // Store geometry and field widths.
  localparam int unsigned MaxClauses  = 1024;
  localparam int unsigned ClauseSlots = 8;
  localparam int unsigned MaxVars     = 1024;
  localparam int unsigned CiW         = 10;
  localparam int unsigned SlotW       = 3;
  localparam int unsigned VarW        = 10;
  localparam int unsigned EntW        = 11;
  localparam int unsigned AddrW       = 13;
  localparam int unsigned CntW        = 11;
  localparam logic [CntW-1:0] CountMax = 11'd2047;

  // Input item kinds.
  localparam logic [1:0] ActWrite  = 2'd0;
  localparam logic [1:0] ActSet    = 2'd1;
  localparam logic [1:0] ActSelect = 2'd2;

  // Literal held by a cell; tneg is the sign of the currently true literal.
  typedef struct packed {
    logic [VarW-1:0] vnum;
    logic            neg;
    logic            tneg;
  } lit_t;

  // One scanned store entry broadcast to all cells.
  typedef struct packed {
    logic            vld;
    logic            first;
    logic            last;
    logic [VarW-1:0] vnum;
    logic            neg;
    logic            val;
  } beat_t;

  // Running best literal handed along the chain.
  typedef struct packed {
    logic            found;
    logic [VarW-1:0] vnum;
    logic            neg;
    logic [CntW-1:0] cnt;
  } best_t;

  // Read pipeline tag.
  typedef struct packed {
    logic vld;
    logic load;
    logic first;
    logic last;
  } tag_t;

endpackage

// ----- src/wmbls_store.sv -----
module wmbls_store (
  input  logic                         clk_i,
  input  logic                         cw_en_i,
  input  logic [wmbls_pkg::AddrW-1:0]  cw_addr_i,
  input  logic [wmbls_pkg::EntW-1:0]   cw_data_i,
  input  logic                         aw_en_i,
  input  logic [wmbls_pkg::VarW-1:0]   aw_addr_i,
  input  logic                         aw_data_i,
  input  logic [wmbls_pkg::AddrW-1:0]  rd_addr_i,
  output logic [wmbls_pkg::EntW-1:0]   ent_o,
  output logic                         val_o
);

  logic [wmbls_pkg::EntW-1:0] cmem [wmbls_pkg::MaxClauses*wmbls_pkg::ClauseSlots];
  logic                       amem [wmbls_pkg::MaxVars];
  logic [wmbls_pkg::EntW-1:0] ent1_q;
  logic [wmbls_pkg::EntW-1:0] ent2_q;
  logic                       val_q;

  // Clause store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cw_en_i) begin
      cmem[cw_addr_i] <= cw_data_i;
    end
    ent1_q <= cmem[rd_addr_i];
  end

  // Assignment lookup of the entry just read; the entry is delayed to match.
  always_ff @(posedge clk_i) begin
    if (aw_en_i) begin
      amem[aw_addr_i] <= aw_data_i;
    end
    val_q  <= amem[ent1_q[wmbls_pkg::VarW-1:0]];
    ent2_q <= ent1_q;
  end

  assign ent_o = ent2_q;
  assign val_o = val_q;

endmodule

// ----- src/wmbls_cell.sv -----
module wmbls_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                clr_i,
  input  wmbls_pkg::lit_t     lit_i,
  output wmbls_pkg::lit_t     lit_o,
  input  wmbls_pkg::beat_t    beat_i,
  input  wmbls_pkg::best_t    best_i,
  output wmbls_pkg::best_t    best_o
);

  wmbls_pkg::lit_t                 lit_q;
  wmbls_pkg::best_t                best_q, best_d;
  logic [wmbls_pkg::CntW-1:0]      cnt_q;
  logic                            has_q, oth_q;
  logic                            match, other, has_n, oth_n;

  // Literal shifts in from the upper neighbor while the clause loads.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lit_q <= lit_i;
    end
  end

  // Classify the broadcast entry against this cell's true literal.
  always_comb begin
    match = (beat_i.vnum != '0) && (beat_i.vnum == lit_q.vnum) && (beat_i.neg == lit_q.tneg);
    other = (beat_i.vnum != '0) && !match && (beat_i.val ^ beat_i.neg);
    has_n = (has_q && !beat_i.first) || match;
    oth_n = (oth_q && !beat_i.first) || other;
  end

  // Per-clause flags and the break counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      has_q <= 1'b0;
      oth_q <= 1'b0;
    end else if (clr_i) begin
      cnt_q <= '0;
      has_q <= 1'b0;
      oth_q <= 1'b0;
    end else if (beat_i.vld) begin
      has_q <= has_n;
      oth_q <= oth_n;
      if (beat_i.last && has_n && !oth_n && (cnt_q < wmbls_pkg::CountMax)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Keep the earlier best unless none was found or this literal's break count is strictly lower.
  always_comb begin
    best_d = best_i;
    if ((lit_q.vnum != '0) && (!best_i.found || (cnt_q < best_i.cnt))) begin
      best_d.found = 1'b1;
      best_d.vnum  = lit_q.vnum;
      best_d.neg   = lit_q.neg;
      best_d.cnt   = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign lit_o  = lit_q;
  assign best_o = best_q;

endmodule

// ----- src/walksat_min_break_literal_select_top.sv -----
// Writes (clause literal, variable value) are stored while idle.
// For a select, the slots of its clause are read through the single store read port first, then
// every slot of every clause in use is scanned. One item is in flight at a time.
// After reset a clearing pass over all 8192 clause entries empties the stores; no item is
// accepted during it, configuration writes are taken at any time.
module walksat_min_break_literal_select_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_tvalid,
  output logic        s_tready,
  // clause_index[9:0], slot_index[12:10], variable[22:13], negated[23], value[24]
  input  logic [31:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // chosen_variable[9:0], chosen_negated[10], break_count[21:11], clause_empty[22]
  output logic [23:0] m_tdata
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StDrain = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;
  localparam int unsigned Cells  = wmbls_pkg::ClauseSlots;

  logic [2:0]                      state_q, state_d;
  logic [wmbls_pkg::AddrW-1:0]     addr_q, addr_d;
  logic [3:0]                      wait_q, wait_d;
  logic [10:0]                     ccount_q;
  logic [10:0]                     n_eff;
  logic [wmbls_pkg::AddrW-1:0]     scan_end;
  wmbls_pkg::tag_t                 tag0, tag1_q, tag2_q;
  logic                            cw_en, aw_en, aw_data, accept, clr;
  logic [wmbls_pkg::AddrW-1:0]     cw_addr, rd_addr;
  logic [wmbls_pkg::EntW-1:0]      cw_data, ent;
  logic [wmbls_pkg::VarW-1:0]      aw_addr;
  logic                            val;
  logic                            out_vld_q;
  logic [23:0]                     out_q;
  wmbls_pkg::beat_t                beat;
  wmbls_pkg::lit_t                 lit_in [Cells];
  wmbls_pkg::lit_t                 lit_out [Cells];
  wmbls_pkg::best_t                best_in [Cells];
  wmbls_pkg::best_t                best_out [Cells];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccount_q <= '0;
    end else if (cfg_we_i) begin
      ccount_q <= cfg_wdata_i;
    end
  end

  assign n_eff    = (ccount_q > 11'd1024) ? 11'd1024 : ccount_q;
  assign scan_end = {n_eff[wmbls_pkg::CiW-1:0] - 1'b1, {wmbls_pkg::SlotW{1'b1}}};

  assign s_tready = (state_q == StIdle);
  assign accept   = s_tvalid && s_tready;
  assign clr      = accept && (s_tuser == wmbls_pkg::ActSelect);

  // Sequencer: clearing pass, clause load, store scan and chain drain.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    wait_d  = wait_q;
    tag0    = '0;
    rd_addr = addr_q;
    cw_en   = 1'b0;
    cw_addr = {s_tdata[9:0], s_tdata[12:10]};
    cw_data = {s_tdata[23], s_tdata[22:13]};
    aw_en   = 1'b0;
    aw_addr = s_tdata[22:13];
    aw_data = s_tdata[24];
    case (state_q)
      StClear: begin
        cw_en   = 1'b1;
        cw_addr = addr_q;
        cw_data = '0;
        aw_en   = 1'b1;
        aw_addr = addr_q[wmbls_pkg::VarW-1:0];
        aw_data = 1'b0;
        addr_d  = addr_q + 1'b1;
        if (addr_q == {wmbls_pkg::AddrW{1'b1}}) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          case (s_tuser)
            wmbls_pkg::ActWrite:  cw_en = 1'b1;
            wmbls_pkg::ActSet:    aw_en = 1'b1;
            wmbls_pkg::ActSelect: begin
              addr_d  = {s_tdata[9:0], {wmbls_pkg::SlotW{1'b0}}};
              state_d = StLoad;
            end
            default: ;
          endcase
        end
      end
      StLoad: begin
        tag0.vld  = 1'b1;
        tag0.load = 1'b1;
        addr_d    = addr_q + 1'b1;
        if (addr_q[wmbls_pkg::SlotW-1:0] == {wmbls_pkg::SlotW{1'b1}}) begin
          addr_d = '0;
          wait_d = '0;
          state_d = (n_eff == '0) ? StDrain : StScan;
        end
      end
      StScan: begin
        tag0.vld   = 1'b1;
        tag0.first = (addr_q[wmbls_pkg::SlotW-1:0] == '0);
        tag0.last  = (addr_q[wmbls_pkg::SlotW-1:0] == {wmbls_pkg::SlotW{1'b1}});
        addr_d     = addr_q + 1'b1;
        if (addr_q == scan_end) begin
          wait_d  = '0;
          state_d = StDrain;
        end
      end
      StDrain: begin
        wait_d = wait_q + 1'b1;
        if (wait_q == 4'd12) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || m_tready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      addr_q  <= '0;
      wait_q  <= '0;
      tag1_q  <= '0;
      tag2_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      wait_q  <= wait_d;
      tag1_q  <= tag0;
      tag2_q  <= tag1_q;
    end
  end

  wmbls_store u_store (
    .clk_i     (clk_i),
    .cw_en_i   (cw_en),
    .cw_addr_i (cw_addr),
    .cw_data_i (cw_data),
    .aw_en_i   (aw_en),
    .aw_addr_i (aw_addr),
    .aw_data_i (aw_data),
    .rd_addr_i (rd_addr),
    .ent_o     (ent),
    .val_o     (val)
  );

  // Scanned entry as seen by every cell.
  always_comb begin
    beat.vld   = tag2_q.vld && !tag2_q.load;
    beat.first = tag2_q.first;
    beat.last  = tag2_q.last;
    beat.vnum  = ent[wmbls_pkg::VarW-1:0];
    beat.neg   = ent[wmbls_pkg::VarW];
    beat.val   = val;
  end

  // Row of cells: literals shift down on load, the best moves up.
  for (genvar k = 0; k < Cells; k++) begin : g_cell
    if (k == Cells - 1) begin : g_top
      assign lit_in[k] = '{vnum: ent[wmbls_pkg::VarW-1:0], neg: ent[wmbls_pkg::VarW],
                           tneg: ~val};
    end else begin : g_mid
      assign lit_in[k] = lit_out[k+1];
    end
    if (k == 0) begin : g_first
      assign best_in[k] = '0;
    end else begin : g_next
      assign best_in[k] = best_out[k-1];
    end
    wmbls_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (tag2_q.vld && tag2_q.load),
      .clr_i  (clr),
      .lit_i  (lit_in[k]),
      .lit_o  (lit_out[k]),
      .beat_i (beat),
      .best_i (best_in[k]),
      .best_o (best_out[k])
    );
  end

  // Output register; a finished result waits here for its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == StDone) && (!out_vld_q || m_tready)) begin
      out_vld_q <= 1'b1;
    end else if (m_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StDone) && (!out_vld_q || m_tready)) begin
      out_q <= {1'b0, ~best_out[Cells-1].found, best_out[Cells-1].cnt,
                best_out[Cells-1].neg, best_out[Cells-1].vnum};
    end
  end

  assign m_tvalid = out_vld_q;
  assign m_tdata  = out_q;

endmodule
